// File: rtl/rsh_pkg.sv
// Package for the ray-sphere hit test: widths and the types passed between stages.
`default_nettype none

package rsh_pkg;

    // Coordinate width; the fraction is half of it
    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = COORD_WIDTH / 2;
    localparam int RAD_W       = COORD_WIDTH - 1;

    // L = C - O and the products of stage two
    localparam int L_W    = COORD_WIDTH + 1;
    localparam int PROD_W = L_W + COORD_WIDTH;
    localparam int SQ_W   = 2 * L_W;
    localparam int RR_W   = 2 * RAD_W;

    // Sums of three products, with headroom
    localparam int ACC_W = SQ_W + 2;

    // Split of tca for the squaring stage
    localparam int LO_W = (ACC_W + 1) / 2;
    localparam int HI_W = ACC_W - LO_W;
    localparam int HH_W = 2 * HI_W;
    localparam int HL_W = HI_W + LO_W + 1;
    localparam int L2_W = 2 * LO_W;
    localparam int RHS_W = 2 * ACC_W;

    // Final compare width
    localparam int LHS_W = ACC_W + 2 * FRAC_BITS;
    localparam int CMP_W = ((LHS_W > RHS_W) ? LHS_W : RHS_W) + 1;

    typedef struct packed {
        logic signed [ACC_W-1:0] tca;
        logic signed [ACC_W-1:0] diff;
    } t_geo;

    typedef struct packed {
        logic signed [RHS_W-1:0] rhs;
        logic signed [ACC_W-1:0] diff;
        logic                    tca_neg;
        logic                    in_sphere;
    } t_sqr;

endpackage

`default_nettype wire

// File: rtl/rsh_if.sv
// Handshake interfaces for the ray item channel and the hit result channel.
`default_nettype none

interface rsh_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rsh_pkg::COORD_WIDTH-1:0] origin_x;
    logic signed [rsh_pkg::COORD_WIDTH-1:0] origin_y;
    logic signed [rsh_pkg::COORD_WIDTH-1:0] origin_z;
    logic signed [rsh_pkg::COORD_WIDTH-1:0] dir_x;
    logic signed [rsh_pkg::COORD_WIDTH-1:0] dir_y;
    logic signed [rsh_pkg::COORD_WIDTH-1:0] dir_z;
    logic signed [rsh_pkg::COORD_WIDTH-1:0] center_x;
    logic signed [rsh_pkg::COORD_WIDTH-1:0] center_y;
    logic signed [rsh_pkg::COORD_WIDTH-1:0] center_z;
    logic        [rsh_pkg::RAD_W-1:0]       radius;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, radius,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, radius,
        output ready
    );
endinterface

interface rsh_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

// File: rtl/rsh_dot.sv
// Stages one to three: L = C - O, the dot products, and the sums tca and L.L - r^2.
`default_nettype none

module rsh_dot (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rsh_in_if.sink        i_in,
    output logic          o_valid,
    output rsh_pkg::t_geo o_geo,
    input  wire logic     i_ready
);

    logic w_en1;
    logic w_en2;
    logic w_en3;

    // Stage 1 registers
    logic                             r_v1;
    logic signed [rsh_pkg::L_W-1:0]   r_l [3];
    logic signed [rsh_pkg::COORD_WIDTH-1:0] r_d [3];
    logic        [rsh_pkg::RAD_W-1:0] r_rad;
    logic signed [rsh_pkg::L_W-1:0]   n_l [3];

    // Stage 2 registers
    logic                              r_v2;
    logic signed [rsh_pkg::PROD_W-1:0] r_ld [3];
    logic signed [rsh_pkg::SQ_W-1:0]   r_sq [3];
    logic        [rsh_pkg::RR_W-1:0]   r_rr;
    logic signed [rsh_pkg::PROD_W-1:0] n_ld [3];
    logic signed [rsh_pkg::SQ_W-1:0]   n_sq [3];
    logic        [rsh_pkg::RR_W-1:0]   n_rr;

    // Stage 3 registers
    logic          r_v3;
    rsh_pkg::t_geo r_geo;
    rsh_pkg::t_geo n_geo;

    // Advance a stage when it is empty or the next one advances
    assign w_en3      = !r_v3 || i_ready;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign i_in.ready = w_en1;

    // Stage 1: vector from origin to center
    always_comb begin
        n_l[0] = rsh_pkg::L_W'(i_in.center_x) - rsh_pkg::L_W'(i_in.origin_x);
        n_l[1] = rsh_pkg::L_W'(i_in.center_y) - rsh_pkg::L_W'(i_in.origin_y);
        n_l[2] = rsh_pkg::L_W'(i_in.center_z) - rsh_pkg::L_W'(i_in.origin_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_in.valid) begin
            r_l   <= n_l;
            r_d[0] <= i_in.dir_x;
            r_d[1] <= i_in.dir_y;
            r_d[2] <= i_in.dir_z;
            r_rad <= i_in.radius;
        end
    end

    // Stage 2: two multiplies per lane (L*D and L*L) and the radius square
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ld[k] = rsh_pkg::PROD_W'(r_l[k]) * rsh_pkg::PROD_W'(r_d[k]);
            n_sq[k] = rsh_pkg::SQ_W'(r_l[k]) * rsh_pkg::SQ_W'(r_l[k]);
        end
        n_rr = rsh_pkg::RR_W'(r_rad) * rsh_pkg::RR_W'(r_rad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r_ld <= n_ld;
            r_sq <= n_sq;
            r_rr <= n_rr;
        end
    end

    // Stage 3: sum the lanes; diff = L.L - r^2
    always_comb begin
        n_geo.tca  = rsh_pkg::ACC_W'(r_ld[0]) + rsh_pkg::ACC_W'(r_ld[1])
                   + rsh_pkg::ACC_W'(r_ld[2]);
        n_geo.diff = rsh_pkg::ACC_W'(r_sq[0]) + rsh_pkg::ACC_W'(r_sq[1])
                   + rsh_pkg::ACC_W'(r_sq[2])
                   - $signed(rsh_pkg::ACC_W'(r_rr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_v2) begin
            r_geo <= n_geo;
        end
    end

    assign o_valid = r_v3;
    assign o_geo   = r_geo;

    // An accepted item lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_v1)
        else $error("accepted item missing from stage 1");

    // A stalled stage 3 holds its sums
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_ready |=> r_v3 && $stable(r_geo))
        else $error("stage 3 changed while stalled");

    // With every stage full and the exit stalled, take no item
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && !i_ready |-> !i_in.ready)
        else $error("item taken into a full, stalled pipeline");

endmodule

`default_nettype wire

// File: rtl/rsh_sq.sv
// Stages four and five: square tca as three partial products, then sum them.
`default_nettype none

module rsh_sq (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire rsh_pkg::t_geo i_geo,
    output logic          o_ready,
    output logic          o_valid,
    output rsh_pkg::t_sqr o_sqr,
    input  wire logic     i_ready
);

    logic w_en4;
    logic w_en5;

    logic signed [rsh_pkg::HI_W-1:0] w_hi;
    logic        [rsh_pkg::LO_W-1:0] w_lo;

    // Stage 4 registers
    logic                             r_v4;
    logic signed [rsh_pkg::HH_W-1:0]  r_hh;
    logic signed [rsh_pkg::HL_W-1:0]  r_hl;
    logic        [rsh_pkg::L2_W-1:0]  r_l2;
    logic signed [rsh_pkg::ACC_W-1:0] r_diff4;
    logic                             r_neg4;
    logic signed [rsh_pkg::HH_W-1:0]  n_hh;
    logic signed [rsh_pkg::HL_W-1:0]  n_hl;
    logic        [rsh_pkg::L2_W-1:0]  n_l2;

    // Stage 5 registers
    logic          r_v5;
    rsh_pkg::t_sqr r_sqr;
    rsh_pkg::t_sqr n_sqr;

    assign w_en5   = !r_v5 || i_ready;
    assign w_en4   = !r_v4 || w_en5;
    assign o_ready = w_en4;

    // Stage 4: tca = hi * 2^LO_W + lo, hi signed, lo unsigned
    assign w_hi = $signed(i_geo.tca[rsh_pkg::ACC_W-1:rsh_pkg::LO_W]);
    assign w_lo = i_geo.tca[rsh_pkg::LO_W-1:0];

    always_comb begin
        n_hh = rsh_pkg::HH_W'(w_hi) * rsh_pkg::HH_W'(w_hi);
        n_hl = rsh_pkg::HL_W'(w_hi) * $signed(rsh_pkg::HL_W'(w_lo));
        n_l2 = rsh_pkg::L2_W'(w_lo) * rsh_pkg::L2_W'(w_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en4) begin
            r_v4 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4 && i_valid) begin
            r_hh    <= n_hh;
            r_hl    <= n_hl;
            r_l2    <= n_l2;
            r_diff4 <= i_geo.diff;
            r_neg4  <= i_geo.tca[rsh_pkg::ACC_W-1];
        end
    end

    // Stage 5: hi^2 * 2^(2*LO_W) + hi*lo * 2^(LO_W+1) + lo^2
    always_comb begin
        n_sqr.rhs       = (rsh_pkg::RHS_W'(r_hh) << (2 * rsh_pkg::LO_W))
                        + (rsh_pkg::RHS_W'(r_hl) << (rsh_pkg::LO_W + 1))
                        + $signed(rsh_pkg::RHS_W'(r_l2));
        n_sqr.diff      = r_diff4;
        n_sqr.tca_neg   = r_neg4;
        n_sqr.in_sphere = r_diff4[rsh_pkg::ACC_W-1] || (r_diff4 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en5) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5 && r_v4) begin
            r_sqr <= n_sqr;
        end
    end

    assign o_valid = r_v5;
    assign o_sqr   = r_sqr;

    // A square never comes out negative
    a_rhs_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> !r_sqr.rhs[rsh_pkg::RHS_W-1])
        else $error("tca square is negative");

    // A stalled stage 5 holds its result
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && !i_ready |=> r_v5 && $stable(r_sqr))
        else $error("stage 5 changed while stalled");

    // An empty stage 4 always takes an item
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v4 |-> o_ready)
        else $error("empty stage 4 refused an item");

endmodule

`default_nettype wire

// File: rtl/ray_sphere_hit_test_core.sv
// Top level of the ray-sphere hit test: pipeline stages and the final compare.
// Six stages, each set by one multiply or wide add, carry a ray item to its hit item.
// Throughput: one item per cycle while the output is not stalled.
// A stalled output holds only the stages behind it until they fill; bubbles collapse.
// Reset (synchronous, active low) clears every stage valid bit; data is not cleared.
`default_nettype none

module ray_sphere_hit_test_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rsh_in_if.sink    i_in,
    rsh_out_if.source o_out
);

    logic          w_geo_valid;
    logic          w_geo_ready;
    rsh_pkg::t_geo w_geo;
    logic          w_v5;
    logic          w_rdy5;
    rsh_pkg::t_sqr w_sqr;

    logic                             w_en6;
    logic signed [rsh_pkg::CMP_W-1:0] w_lhs;
    logic signed [rsh_pkg::CMP_W-1:0] w_rhs;
    logic                             n_hit;
    logic                             r_ov;
    logic                             r_hit;

    rsh_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_geo_valid),
        .o_geo   (w_geo),
        .i_ready (w_geo_ready)
    );

    rsh_sq u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_geo_valid),
        .i_geo   (w_geo),
        .o_ready (w_geo_ready),
        .o_valid (w_v5),
        .o_sqr   (w_sqr),
        .i_ready (w_rdy5)
    );

    // Stage 6: miss when (L.L - r^2) * 2^(2*FRAC) > tca^2, else hit unless
    // the sphere lies behind an origin that is outside it
    assign w_en6  = !r_ov || o_out.ready;
    assign w_rdy5 = w_en6;
    assign w_lhs  = rsh_pkg::CMP_W'(w_sqr.diff) << (2 * rsh_pkg::FRAC_BITS);
    assign w_rhs  = rsh_pkg::CMP_W'(w_sqr.rhs);
    assign n_hit  = !(w_lhs > w_rhs) && (!w_sqr.tca_neg || w_sqr.in_sphere);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en6) begin
            r_ov <= w_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en6 && w_v5) begin
            r_hit <= n_hit;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.hit   = r_hit;

    // An empty output register never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ov |-> i_in.ready)
        else $error("input blocked with an empty output register");

    // A finished item in stage 5 moves to the output when it may
    a_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v5 && w_en6 |=> r_ov)
        else $error("stage 5 item lost on its way out");

    // A stalled output with stage 5 full holds stage 5
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_out.ready && w_v5 |-> !w_rdy5)
        else $error("stage 5 released into a stalled output");

endmodule

`default_nettype wire
